>>> hw/rtl/pfa_pkg.sv
package pfa_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned FC_W    = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_ALLOC  = 3'd2,
    MODE_CONTIG = 3'd3,
    MODE_FREE   = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_WAIT,
    ST_ALLOC_WAIT,
    ST_SCAN,
    ST_WALK_RD,
    ST_WALK_DATA,
    ST_PAGE_CLR,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic init;
    logic mem_rd;
    logic mem_wr;
    logic set_rdata;
    logic alloc_rd;
    logic alloc_take;
    logic free_push;
    logic page_clr;
    logic scan_init;
    logic scan_step;
    logic walk_rd;
    logic walk_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic  fmt_start;
    mode_e mode;
    logic  addr_ok;
    logic  head_nil;
    logic  count_ok;
    logic  used_ok;
    logic  frame_in_fc;
    logic  ptr_last;
    logic  off_last;
    logic  scan_end;
    logic  found;
    logic  cur_nil;
    logic  out_free;
  } sts_t;

endpackage

>>> hw/rtl/physical_frame_allocator.sv
// Free clears the freed frame's page byte by byte (page clear loop) before its result;
// alloc contiguous scans the free marks for a run of count frames, then walks the free list.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset and every frame_count write format the memory: all MAX_FRAMES * PAGE_BYTES bytes are
// cleared, one byte per cycle, with no transaction accepted meanwhile.
module physical_frame_allocator #(
  parameter int unsigned MAX_FRAMES = 256,
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pfa_pkg::FC_W-1:0]     cfg_frame_count_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pfa_pkg::MODE_W-1:0]   mode_i,
  input  logic [pfa_pkg::ADDR_W-1:0]   address_i,
  input  logic [pfa_pkg::DATA_W-1:0]   write_data_i,
  input  logic [pfa_pkg::COUNT_W-1:0]  count_i,
  input  logic [pfa_pkg::FRAME_W-1:0]  frame_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [pfa_pkg::DATA_W-1:0]   read_data_o,
  output logic [pfa_pkg::FRAME_W-1:0]  frame_number_o
);
  import pfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfa_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_frame_count_i (cfg_frame_count_i),
    .mode_i            (mode_i),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .count_i           (count_i),
    .frame_i           (frame_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .read_data_o       (read_data_o),
    .frame_number_o    (frame_number_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

>>> hw/rtl/pfa_ctrl.sv
module pfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pfa_pkg::sts_t sts_i,
  output pfa_pkg::cmd_t cmd_o
);
  import pfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.init = 1'b1;
        if (sts_i.ptr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_RESULT;
        case (sts_i.mode)
          MODE_READ: begin
            if (sts_i.addr_ok) begin
              cmd_o.mem_rd = 1'b1;
              state_d = ST_RD_WAIT;
            end
          end
          MODE_WRITE: begin
            cmd_o.mem_wr = sts_i.addr_ok;
          end
          MODE_ALLOC: begin
            if (!sts_i.head_nil) begin
              cmd_o.alloc_rd = 1'b1;
              state_d = ST_ALLOC_WAIT;
            end
          end
          MODE_CONTIG: begin
            if (sts_i.count_ok) begin
              cmd_o.scan_init = 1'b1;
              state_d = ST_SCAN;
            end
          end
          MODE_FREE: begin
            if (sts_i.used_ok) begin
              cmd_o.free_push = 1'b1;
              if (sts_i.frame_in_fc) state_d = ST_PAGE_CLR;
            end
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_RD_WAIT: begin
        cmd_o.set_rdata = 1'b1;
        state_d = ST_RESULT;
      end
      ST_ALLOC_WAIT: begin
        cmd_o.alloc_take = 1'b1;
        state_d = ST_RESULT;
      end
      ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.found) state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        if (sts_i.cur_nil) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d = ST_WALK_DATA;
        end
      end
      ST_WALK_DATA: begin
        cmd_o.walk_step = 1'b1;
        state_d = ST_WALK_RD;
      end
      ST_PAGE_CLR: begin
        cmd_o.page_clr = 1'b1;
        if (sts_i.off_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    if (sts_i.fmt_start) begin
      cmd_o      = '0;
      in_ready_o = 1'b0;
      state_d    = ST_CLEAR;
    end
  end

endmodule

>>> hw/rtl/pfa_datapath.sv
module pfa_datapath #(
  parameter int unsigned MAX_FRAMES = 256,
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [pfa_pkg::FC_W-1:0]     cfg_frame_count_i,
  input  logic [pfa_pkg::MODE_W-1:0]   mode_i,
  input  logic [pfa_pkg::ADDR_W-1:0]   address_i,
  input  logic [pfa_pkg::DATA_W-1:0]   write_data_i,
  input  logic [pfa_pkg::COUNT_W-1:0]  count_i,
  input  logic [pfa_pkg::FRAME_W-1:0]  frame_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [pfa_pkg::DATA_W-1:0]   read_data_o,
  output logic [pfa_pkg::FRAME_W-1:0]  frame_number_o,
  input  pfa_pkg::cmd_t                cmd_i,
  output pfa_pkg::sts_t                sts_o
);
  import pfa_pkg::*;

  localparam int unsigned STORE = MAX_FRAMES * PAGE_BYTES;
  localparam int unsigned AW    = $clog2(STORE);
  localparam int unsigned FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned LW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PW    = $clog2(PAGE_BYTES);
  localparam int unsigned XW    = ((AW > FC_W) ? AW : FC_W) + 1;
  localparam int unsigned LIMW  = FC_W + $clog2(PAGE_BYTES + 1);
  localparam int unsigned CW0   = (LIMW > ADDR_W + 1) ? LIMW : ADDR_W + 1;
  localparam int unsigned CW    = (CW0 > XW) ? CW0 : XW;
  localparam int unsigned FC_RST = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

  logic [DATA_W-1:0] byte_mem [STORE];
  logic [LW-1:0]     link_mem [MAX_FRAMES];

  logic [FC_W-1:0]    fc_q;
  logic [AW-1:0]      ptr_q;
  logic [PW-1:0]      off_q;
  logic [MODE_W-1:0]  mode_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [DATA_W-1:0]  wdata_q;
  logic [COUNT_W-1:0] count_q;
  logic [FRAME_W-1:0] frame_q;
  logic [LW-1:0]      head_q, cur_q, prev_q;
  logic               prev_nil_q;
  logic [XW-1:0]      scan_q, run_q, start_q, end_q;
  logic [MAX_FRAMES-1:0] free_q, used_q;
  logic [DATA_W-1:0]  mem_rd_q;
  logic [LW-1:0]      link_rd_q;
  logic               res_status_q;
  logic [DATA_W-1:0]  res_rdata_q;
  logic [FRAME_W-1:0] res_fnum_q;
  logic               out_valid_q;
  logic               out_status_q;
  logic [DATA_W-1:0]  out_rdata_q;
  logic [FRAME_W-1:0] out_fnum_q;

  localparam logic [LW-1:0] NIL = LW'(MAX_FRAMES);

  logic [FC_W-1:0] cfg_fc;
  logic [XW-1:0]   fc_x, frame_x, count_x, ptr_x, cur_x, run_n, start_n;
  logic [FW-1:0]   fidx;
  logic [CW-1:0]   limit, base;
  logic            addr_ok, mark, found, in_range;
  logic            mem_we, link_we;
  logic [AW-1:0]   mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [FW-1:0]   link_wa, link_ra;
  logic [LW-1:0]   link_wd;

  always_comb begin
    if (cfg_frame_count_i == '0) begin
      cfg_fc = FC_W'(1);
    end else if (CW'(cfg_frame_count_i) > CW'(MAX_FRAMES)) begin
      cfg_fc = FC_W'(MAX_FRAMES);
    end else begin
      cfg_fc = cfg_frame_count_i;
    end
  end

  assign fc_x    = XW'(fc_q);
  assign frame_x = XW'(frame_q);
  assign count_x = XW'(count_q);
  assign ptr_x   = XW'(ptr_q);
  assign cur_x   = XW'(cur_q);
  assign fidx    = frame_x[FW-1:0];
  assign limit   = CW'(fc_q) * CW'(PAGE_BYTES);
  assign base    = CW'(frame_q) * CW'(PAGE_BYTES);
  assign addr_ok = (CW'(addr_q) < limit) && (CW'(addr_q) < CW'(STORE));
  assign mark    = free_q[scan_q[FW-1:0]];
  assign run_n   = mark ? run_q + XW'(1) : '0;
  assign found   = (scan_q < fc_x) && mark && (run_n == count_x);
  assign start_n = scan_q + XW'(1) - count_x;
  assign in_range = (cur_x >= start_q) && (cur_x <= end_q);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_q;
    mem_wd = '0;
    if (cmd_i.init || cmd_i.page_clr) begin
      mem_we = 1'b1;
    end else if (cmd_i.mem_wr) begin
      mem_we = 1'b1;
      mem_wa = AW'(addr_q);
      mem_wd = wdata_q;
    end
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = ptr_q[FW-1:0];
    link_wd = NIL;
    link_ra = cur_q[FW-1:0];
    if (cmd_i.alloc_rd) link_ra = head_q[FW-1:0];
    if (cmd_i.init) begin
      link_we = ptr_x < XW'(MAX_FRAMES);
      link_wd = (ptr_x + XW'(1) < fc_x) ? LW'(ptr_x + XW'(1)) : NIL;
    end else if (cmd_i.free_push) begin
      link_we = 1'b1;
      link_wa = fidx;
      link_wd = head_q;
    end else if (cmd_i.walk_step && in_range && !prev_nil_q) begin
      link_we = 1'b1;
      link_wa = prev_q[FW-1:0];
      link_wd = link_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) byte_mem[mem_wa] <= mem_wd;
    if (cmd_i.mem_rd) mem_rd_q <= byte_mem[AW'(addr_q)];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (cmd_i.alloc_rd || cmd_i.walk_rd) link_rd_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= FC_W'(FC_RST);
      ptr_q       <= '0;
      off_q       <= '0;
      head_q      <= '0;
      free_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        fc_q  <= cfg_fc;
        ptr_q <= '0;
      end else if (cmd_i.init || cmd_i.page_clr) begin
        ptr_q <= ptr_q + AW'(1);
      end else if (cmd_i.free_push) begin
        ptr_q <= AW'(base);
      end
      if (cmd_i.free_push) begin
        off_q <= '0;
      end else if (cmd_i.page_clr) begin
        off_q <= off_q + PW'(1);
      end
      if (cmd_i.init) begin
        head_q <= '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          free_q[i] <= XW'(i) < fc_x;
          used_q[i] <= 1'b0;
        end
      end
      if (cmd_i.alloc_take) begin
        head_q                <= link_rd_q;
        free_q[head_q[FW-1:0]] <= 1'b0;
        used_q[head_q[FW-1:0]] <= 1'b1;
      end
      if (cmd_i.free_push) begin
        head_q       <= LW'(frame_x);
        free_q[fidx] <= 1'b1;
        used_q[fidx] <= 1'b0;
      end
      if (cmd_i.scan_step && found) begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
          if (XW'(i) >= start_n && XW'(i) <= scan_q) begin
            free_q[i] <= 1'b0;
            used_q[i] <= 1'b1;
          end
        end
      end
      if (cmd_i.walk_step && in_range && prev_nil_q) head_q <= link_rd_q;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q       <= mode_i;
      addr_q       <= address_i;
      wdata_q      <= write_data_i;
      count_q      <= count_i;
      frame_q      <= frame_i;
      res_status_q <= 1'b1;
      res_rdata_q  <= '0;
      res_fnum_q   <= '0;
    end
    if (cmd_i.mem_wr || cmd_i.free_push) res_status_q <= 1'b0;
    if (cmd_i.set_rdata) begin
      res_status_q <= 1'b0;
      res_rdata_q  <= mem_rd_q;
    end
    if (cmd_i.alloc_take) begin
      res_status_q <= 1'b0;
      res_fnum_q   <= FRAME_W'(head_q);
    end
    if (cmd_i.scan_init) begin
      scan_q <= '0;
      run_q  <= '0;
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_q + XW'(1);
      run_q  <= run_n;
      if (found) begin
        start_q      <= start_n;
        end_q        <= scan_q;
        res_status_q <= 1'b0;
        res_fnum_q   <= FRAME_W'(start_n);
        cur_q        <= head_q;
        prev_q       <= NIL;
        prev_nil_q   <= 1'b1;
      end
    end
    if (cmd_i.walk_step) begin
      cur_q <= link_rd_q;
      if (!in_range) begin
        prev_q     <= cur_q;
        prev_nil_q <= 1'b0;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_rdata_q  <= res_rdata_q;
      out_fnum_q   <= res_fnum_q;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.fmt_start   = cfg_valid_i;
    sts_o.mode        = mode_e'(mode_q);
    sts_o.addr_ok     = addr_ok;
    sts_o.head_nil    = head_q == NIL;
    sts_o.count_ok    = (count_q != '0) && (count_x <= fc_x);
    sts_o.used_ok     = (frame_x < XW'(MAX_FRAMES)) && used_q[fidx];
    sts_o.frame_in_fc = frame_x < fc_x;
    sts_o.ptr_last    = ptr_q == AW'(STORE - 1);
    sts_o.off_last    = off_q == PW'(PAGE_BYTES - 1);
    sts_o.scan_end    = scan_q >= fc_x;
    sts_o.found       = found;
    sts_o.cur_nil     = cur_q == NIL;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign read_data_o    = out_rdata_q;
  assign frame_number_o = out_fnum_q;

endmodule
